[src/hthq_pkg.sv]
// ============================================================================
// hthq_pkg: shared constants and types for the heightmap height query unit
// Parameter defaults, fixed field widths, and the divide-by-constant factors.
// ============================================================================
package hthq_pkg;

    // Parameter defaults
    localparam int GRID_DIM_DEF    = 256;
    localparam int HEIGHT_BITS_DEF = 8;
    localparam int QUEUE_DEPTH     = 4;

    // Fixed field widths
    localparam int POS_W    = 20;
    localparam int FRAC_W   = 8;
    localparam int CELL_W   = 8;     // grid_col, grid_row, height_value
    localparam int COORD_W  = 11;    // in-tile offset, 0..1279
    localparam int TILE_W   = 9;     // tile index from a position, 0..409
    localparam int OUT_W    = 15;

    // Tile is 5 world units = 1280 raw units
    localparam int TILE_UNITS  = 5;
    localparam int TILE_RAW    = 1280;
    localparam int REM_W       = 3;
    // floor(v / 5) = (v * 3277) >> 14, exact for v < 2^14
    localparam int TILE_DIV_MUL   = 3277;
    localparam int TILE_DIV_MUL_W = 12;
    localparam int TILE_DIV_SHIFT = 14;

    // Output = round(N / 10), saturating
    localparam int ROUND_BIAS = 5;
    localparam int SAT_N      = 327675;   // smallest N giving a result above OUT_MAX
    localparam int V_W        = 18;       // (N + 5) >> 1 below saturation
    // floor(v / 5) = (v * 52429) >> 18, exact for v < 2^18
    localparam int DIV5_MUL   = 52429;
    localparam int DIV5_MUL_W = 16;
    localparam int DIV5_SHIFT = 18;
    localparam logic [OUT_W-1:0] OUT_MAX = 15'h7FFF;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

endpackage

[src/hthq_front.sv]
// ============================================================================
// hthq_front: request intake and classification
// Splits positions into tile and in-tile offset, checks range, picks the
// triangle, and hands one packed request per cycle to the queue while it is not full.
// ============================================================================
module hthq_front #(
    parameter int GRID_DIM    = hthq_pkg::GRID_DIM_DEF,
    parameter int HEIGHT_BITS = hthq_pkg::HEIGHT_BITS_DEF,
    parameter int IDX_BITS    = $clog2(GRID_DIM),
    parameter int REQ_W       = 3 + 2 * hthq_pkg::COORD_W + 2 * IDX_BITS + HEIGHT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [hthq_pkg::CELL_W-1:0]         i_grid_col,
    input  logic [hthq_pkg::CELL_W-1:0]         i_grid_row,
    input  logic [hthq_pkg::CELL_W-1:0]         i_height_value,
    input  logic signed [hthq_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [hthq_pkg::POS_W-1:0]   i_pos_y,
    input  logic                                i_q_full,
    output logic                                o_push,
    output logic [REQ_W-1:0]                    o_req
);

    localparam int CW    = hthq_pkg::COORD_W;
    localparam int DIVPW = CW + hthq_pkg::TILE_DIV_MUL_W;

    typedef struct packed {
        logic                   wr_ok;
        logic                   in_grid;
        logic                   upper;
        logic [CW-1:0]          a;
        logic [CW-1:0]          b;
        logic [IDX_BITS-1:0]    col;
        logic [IDX_BITS-1:0]    row;
        logic [HEIGHT_BITS-1:0] data;
    } t_req;

    logic  r_fv;
    t_req  r_item;
    t_req  n_item;
    logic  in_acc;

    logic [CW-1:0]                  vx, vy, rx, ry;
    logic [DIVPW-1:0]               mx, my;
    logic [hthq_pkg::TILE_W-1:0]    tx, ty;
    logic [hthq_pkg::REM_W-1:0]     rem_x, rem_y;
    logic                           is_write;

    assign o_in_stall = r_fv && i_q_full;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_push     = r_fv && !i_q_full;
    assign o_req      = r_item;

    // integer part of position over 256, then divided by 5
    assign vx = i_pos_x[hthq_pkg::FRAC_W +: CW];
    assign vy = i_pos_y[hthq_pkg::FRAC_W +: CW];
    assign mx = DIVPW'(vx) * DIVPW'(hthq_pkg::TILE_DIV_MUL);
    assign my = DIVPW'(vy) * DIVPW'(hthq_pkg::TILE_DIV_MUL);
    assign tx = mx[hthq_pkg::TILE_DIV_SHIFT +: hthq_pkg::TILE_W];
    assign ty = my[hthq_pkg::TILE_DIV_SHIFT +: hthq_pkg::TILE_W];
    assign rem_x = hthq_pkg::REM_W'(vx - CW'(tx) * CW'(hthq_pkg::TILE_UNITS));
    assign rem_y = hthq_pkg::REM_W'(vy - CW'(ty) * CW'(hthq_pkg::TILE_UNITS));
    assign rx = {rem_x, i_pos_x[hthq_pkg::FRAC_W-1:0]};
    assign ry = {rem_y, i_pos_y[hthq_pkg::FRAC_W-1:0]};

    assign is_write = (hthq_pkg::t_opcode'(i_opcode) == hthq_pkg::OP_WRITE);

    always_comb begin
        n_item = '0;
        if (is_write) begin
            n_item.wr_ok = (32'(i_grid_col) < 32'(GRID_DIM)) &&
                           (32'(i_grid_row) < 32'(GRID_DIM));
            n_item.col   = IDX_BITS'(i_grid_col);
            n_item.row   = IDX_BITS'(i_grid_row);
            n_item.data  = HEIGHT_BITS'(i_height_value);
        end else begin
            n_item.in_grid = !i_pos_x[hthq_pkg::POS_W-1] && !i_pos_y[hthq_pkg::POS_W-1] &&
                             (32'(tx) < 32'(GRID_DIM - 1)) &&
                             (32'(ty) < 32'(GRID_DIM - 1));
            // upper triangle when the y offset is at least the x offset
            n_item.upper  = !(rx > ry);
            n_item.a      = n_item.upper ? ry : rx;
            n_item.b      = n_item.upper ? rx : ry;
            n_item.col    = IDX_BITS'(tx);
            n_item.row    = IDX_BITS'(ty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (in_acc) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= n_item;
        end
    end

    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fv && i_q_full) |=> (r_fv && $stable(r_item)))
        else $error("front request lost while queue full");

endmodule

[src/hthq_queue.sv]
// ============================================================================
// hthq_queue: short request queue
// Register FIFO that decouples intake from the memory and arithmetic side.
// ============================================================================
module hthq_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = hthq_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

[src/hthq_back.sv]
// ============================================================================
// hthq_back: height store and interpolation pipeline
// Four parity banks give all tile corners in one read; then products, sum
// with rounding and saturation, and the divide by five into the output.
// ============================================================================
module hthq_back #(
    parameter int GRID_DIM    = hthq_pkg::GRID_DIM_DEF,
    parameter int HEIGHT_BITS = hthq_pkg::HEIGHT_BITS_DEF,
    parameter int IDX_BITS    = $clog2(GRID_DIM),
    parameter int REQ_W       = 3 + 2 * hthq_pkg::COORD_W + 2 * IDX_BITS + HEIGHT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    input  logic [REQ_W-1:0]            i_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hthq_pkg::OUT_W-1:0]  o_terrain_height,
    output logic                        o_inside_map
);

    localparam int CW     = hthq_pkg::COORD_W;
    localparam int HALF_W = (IDX_BITS > 1) ? IDX_BITS - 1 : 1;
    localparam int BANK_D = 1 << (2 * HALF_W);
    localparam int PW     = CW + HEIGHT_BITS;
    localparam int NW     = PW + 2;
    localparam int MW     = hthq_pkg::V_W + hthq_pkg::DIV5_MUL_W;
    localparam int HB     = HEIGHT_BITS;

    typedef struct packed {
        logic                   wr_ok;
        logic                   in_grid;
        logic                   upper;
        logic [CW-1:0]          a;
        logic [CW-1:0]          b;
        logic [IDX_BITS-1:0]    col;
        logic [IDX_BITS-1:0]    row;
        logic [HEIGHT_BITS-1:0] data;
    } t_req;

    function automatic logic [HB-1:0] pick(input logic [1:0] sel, input logic [HB-1:0] d0,
                                           input logic [HB-1:0] d1, input logic [HB-1:0] d2,
                                           input logic [HB-1:0] d3);
        logic [HB-1:0] res;
        case (sel)
            2'b00:   res = d0;
            2'b01:   res = d1;
            2'b10:   res = d2;
            default: res = d3;
        endcase
        return res;
    endfunction

    t_req                   req;
    logic                   en;
    logic [HALF_W-1:0]      col_half [2];
    logic [HALF_W-1:0]      row_half [2];
    logic [HB-1:0]          rd_data  [4];

    assign req   = t_req'(i_req);
    assign en    = !o_out_valid || !i_out_stall;
    assign o_pop = en && !i_q_empty;

    // bank {pr,pc} holds the corner whose row/col parity is pr/pc;
    // an odd index reaches its even neighbor through a half index plus one
    assign col_half[0] = HALF_W'(req.col >> 1) + HALF_W'(req.col[0]);
    assign col_half[1] = HALF_W'(req.col >> 1);
    assign row_half[0] = HALF_W'(req.row >> 1) + HALF_W'(req.row[0]);
    assign row_half[1] = HALF_W'(req.row >> 1);

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [HB-1:0]       mem [BANK_D];
        logic [HB-1:0]       r_rd;
        logic [2*HALF_W-1:0] addr;
        logic                we;

        assign addr = {row_half[g / 2], col_half[g % 2]};
        assign we   = o_pop && req.wr_ok && ({req.row[0], req.col[0]} == 2'(g));

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[addr] <= req.data;
            end
            if (en) begin
                r_rd <= mem[addr];
            end
        end

        assign rd_data[g] = r_rd;
    end

    // stage 1: bank read
    logic r_v1, r_ins1, r_up1, r_c1, r_r1;
    logic [CW-1:0] r_a1, r_b1;
    // stage 2: corner products
    logic r_v2, r_ins2;
    logic [PW-1:0] r_p1, r_p2, r_p3;
    // stage 3: sum, rounding, saturation
    logic r_v3, r_ins3, r_sat3;
    logic [hthq_pkg::V_W-1:0] r_half3;
    // stage 4: output
    logic r_v4, r_ins4;
    logic [hthq_pkg::OUT_W-1:0] r_h4;

    logic [HB-1:0]  h1, h2, h3;
    logic [CW-1:0]  wa;
    logic [NW-1:0]  n_sum;
    logic [MW-1:0]  quot;

    assign h1 = pick({r_r1, r_c1}, rd_data[0], rd_data[1], rd_data[2], rd_data[3]);
    assign h2 = r_up1 ? pick({!r_r1, r_c1}, rd_data[0], rd_data[1], rd_data[2], rd_data[3])
                      : pick({r_r1, !r_c1}, rd_data[0], rd_data[1], rd_data[2], rd_data[3]);
    assign h3 = pick({!r_r1, !r_c1}, rd_data[0], rd_data[1], rd_data[2], rd_data[3]);
    assign wa = CW'(hthq_pkg::TILE_RAW) - r_a1;

    assign n_sum = NW'(r_p1) + NW'(r_p2) + NW'(r_p3);
    assign quot  = MW'(r_half3) * MW'(hthq_pkg::DIV5_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ins1  <= req.in_grid;
            r_up1   <= req.upper;
            r_c1    <= req.col[0];
            r_r1    <= req.row[0];
            r_a1    <= req.a;
            r_b1    <= req.b;

            r_ins2  <= r_ins1;
            r_p1    <= PW'(wa) * PW'(h1);
            r_p2    <= PW'(r_a1 - r_b1) * PW'(h2);
            r_p3    <= PW'(r_b1) * PW'(h3);

            r_ins3  <= r_ins2;
            r_sat3  <= 32'(n_sum) >= 32'(hthq_pkg::SAT_N);
            r_half3 <= hthq_pkg::V_W'((32'(n_sum) + 32'(hthq_pkg::ROUND_BIAS)) >> 1);

            r_ins4  <= r_ins3;
            if (!r_ins3) begin
                r_h4 <= '0;
            end else if (r_sat3) begin
                r_h4 <= hthq_pkg::OUT_MAX;
            end else begin
                r_h4 <= quot[hthq_pkg::DIV5_SHIFT +: hthq_pkg::OUT_W];
            end
        end
    end

    assign o_out_valid      = r_v4;
    assign o_terrain_height = r_h4;
    assign o_inside_map     = r_ins4;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_inside_map) |-> (o_terrain_height == '0))
        else $error("nonzero height for write or outside query");

endmodule

[src/heightmap_triangle_height_query_unit.sv]
// ============================================================================
// heightmap_triangle_height_query_unit: terrain height lookup over a grid
// Write requests fill a square height grid; query requests return the
// barycentric height of the tile triangle under a fixed-point position.
// ============================================================================
// Throughput is one request per cycle, writes and queries mixed freely, as
// long as the output is not stalled; a request passes the intake register,
// queue, bank read, products, sum and divide registers on its way out. The
// store is split into four banks by row and column parity, so the three
// corners of any tile come from different banks in a single read, and a
// write touches one bank in that same stage, keeping writes and queries
// in order. The store is not cleared at reset: reading an entry
// that was never written returns whatever the memory holds. Positions carry 8
// fraction bits; a tile is 1280 raw units. Negative positions, or a tile in or
// beyond the last row or column, give a zero height with o_inside_map low. Writes
// with an index beyond the grid are dropped but still produce one zero
// response. The queue between intake and the pipeline lets the input keep
// accepting while the output is briefly stalled.
// ============================================================================
module heightmap_triangle_height_query_unit #(
    parameter int GRID_DIM    = hthq_pkg::GRID_DIM_DEF,
    parameter int HEIGHT_BITS = hthq_pkg::HEIGHT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [hthq_pkg::CELL_W-1:0]         i_grid_col,
    input  logic [hthq_pkg::CELL_W-1:0]         i_grid_row,
    input  logic [hthq_pkg::CELL_W-1:0]         i_height_value,
    input  logic signed [hthq_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [hthq_pkg::POS_W-1:0]   i_pos_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hthq_pkg::OUT_W-1:0]          o_terrain_height,
    output logic                                o_inside_map
);

    localparam int IDX_BITS = $clog2(GRID_DIM);
    localparam int REQ_W    = 3 + 2 * hthq_pkg::COORD_W + 2 * IDX_BITS + HEIGHT_BITS;

    logic             q_full, q_empty, q_push, q_pop;
    logic [REQ_W-1:0] push_req, pop_req;

    // intake: tile split, range check, triangle pick
    hthq_front #(
        .GRID_DIM    (GRID_DIM),
        .HEIGHT_BITS (HEIGHT_BITS),
        .IDX_BITS    (IDX_BITS),
        .REQ_W       (REQ_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_grid_col     (i_grid_col),
        .i_grid_row     (i_grid_row),
        .i_height_value (i_height_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_req          (push_req)
    );

    hthq_queue #(
        .WIDTH (REQ_W),
        .DEPTH (hthq_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (pop_req),
        .o_empty (q_empty)
    );

    // banked store and interpolation pipeline; the whole pipeline holds
    // when a finished response is stalled at the output
    hthq_back #(
        .GRID_DIM    (GRID_DIM),
        .HEIGHT_BITS (HEIGHT_BITS),
        .IDX_BITS    (IDX_BITS),
        .REQ_W       (REQ_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .o_pop            (q_pop),
        .i_req            (pop_req),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_terrain_height (o_terrain_height),
        .o_inside_map     (o_inside_map)
    );

endmodule
